// ----- hw/rtl/cds_pkg.sv -----
// Package for the calendar date stepper: request and result types, command
// and status structs, operation codes, state encoding and month length lookup.
// No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_FWD  = 2'd0;
    localparam t_op OP_BWD  = 2'd1;
    localparam t_op OP_LOAD = 2'd2;
    localparam t_op OP_NOP  = 2'd3;

    localparam logic [13:0] C_YEAR_SPAN  = 14'd10000;
    localparam logic [13:0] C_CENT_YEARS = 14'd100;
    localparam logic [12:0] C_CENT_RECIP = 13'd5243;
    localparam logic [6:0]  C_LAST_YY    = 7'd99;
    localparam logic [6:0]  C_LAST_CENT  = 7'd99;
    localparam logic [6:0]  C_RESET_CENT = 7'd20;
    localparam logic [6:0]  C_RESET_YY   = 7'd0;
    localparam logic [3:0]  C_DEC_MONTH  = 4'd12;
    localparam logic [4:0]  C_LAST_DAY   = 5'd31;

    typedef struct packed {
        t_op         op;
        logic [15:0] day_count;
        logic [13:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
    } t_in;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic        load_rejected;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic load_check;
        logic day_step;
        logic out_write;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic div_last;
        logic out_free;
    } t_status;

    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic f_leap(input logic [6:0] cent, input logic [6:0] yy);
        logic leap;
        if (yy != 7'd0) begin
            leap = (yy[1:0] == 2'd0);
        end else begin
            leap = (cent[1:0] == 2'd0);
        end
        return leap;
    endfunction

endpackage

// ----- hw/rtl/cds_ctrl.sv -----
// Controller state machine of the calendar date stepper.
// Depends on cds_pkg for the state, command and status types.
`timescale 1ns / 1ps

module cds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cds_pkg::t_op   i_op,
    input  cds_pkg::t_status i_status,
    output logic           o_stall,
    output cds_pkg::t_cmd  o_cmd
);

    cds_pkg::t_state r_state;
    cds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            cds_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_op)
                        cds_pkg::OP_FWD, cds_pkg::OP_BWD: n_state = cds_pkg::S_STEP;
                        cds_pkg::OP_LOAD:                 n_state = cds_pkg::S_DIV;
                        default:                          n_state = cds_pkg::S_DONE;
                    endcase
                end
            end
            cds_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = cds_pkg::S_CHECK;
                end
            end
            cds_pkg::S_CHECK: begin
                o_cmd.load_check = 1'b1;
                n_state          = cds_pkg::S_DONE;
            end
            cds_pkg::S_STEP: begin
                if (i_status.count_zero) begin
                    n_state = cds_pkg::S_DONE;
                end else begin
                    o_cmd.day_step = 1'b1;
                end
            end
            cds_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = cds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cds_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/cds_dp.sv -----
// Datapath of the calendar date stepper: date registers held as century and
// year within century, the load year divider, the day stepper and the result register.
// Depends on cds_pkg for types, constants and the month length lookup.
`timescale 1ns / 1ps

module cds_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cds_pkg::t_in     i_in,
    input  cds_pkg::t_cmd    i_cmd,
    input  logic             i_stall,
    output cds_pkg::t_status o_status,
    output logic             o_valid,
    output cds_pkg::t_out    o_out
);

    logic [6:0]    r_cent;
    logic [6:0]    r_yy;
    logic [3:0]    r_month;
    logic [4:0]    r_day;
    cds_pkg::t_op  r_op;
    logic [15:0]   r_cnt;
    logic [3:0]    r_lm;
    logic [4:0]    r_ld;
    logic [13:0]   r_rem;
    logic [6:0]    r_quo;
    logic          r_div_hi;
    logic          r_rej;
    logic          r_out_valid;
    cds_pkg::t_out r_out;

    logic [6:0]  n_cent;
    logic [6:0]  n_yy;
    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic        cur_leap;
    logic        load_leap;
    logic        load_ok;
    logic [4:0]  load_len;
    logic [25:0] quo_prod;
    logic [13:0] cent_part;
    logic [13:0] out_year;
    logic [3:0]  prev_month;

    assign cur_leap   = cds_pkg::f_leap(r_cent, r_yy);
    assign load_leap  = cds_pkg::f_leap(r_quo, r_rem[6:0]);
    assign load_len   = cds_pkg::f_month_len(r_lm, load_leap);
    assign load_ok    = (r_lm >= 4'd1) && (r_lm <= cds_pkg::C_DEC_MONTH)
                     && (r_ld >= 5'd1) && (r_ld <= load_len);
    // The century is the year times the scaled reciprocal of 100, shifted right by 19.
    assign quo_prod   = 26'(r_rem) * 26'(cds_pkg::C_CENT_RECIP);
    assign cent_part  = 14'(r_quo) * cds_pkg::C_CENT_YEARS;
    assign prev_month = r_month - 4'd1;
    assign out_year   = 14'(r_cent) * cds_pkg::C_CENT_YEARS + 14'(r_yy);

    assign o_status.count_zero = (r_cnt == 16'd0);
    assign o_status.div_last   = !r_div_hi;
    assign o_status.out_free   = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_comb begin
        n_cent  = r_cent;
        n_yy    = r_yy;
        n_month = r_month;
        n_day   = r_day;
        if (r_op == cds_pkg::OP_FWD) begin
            if (r_month == cds_pkg::C_DEC_MONTH && r_day == cds_pkg::C_LAST_DAY) begin
                n_month = 4'd1;
                n_day   = 5'd1;
                if (r_yy == cds_pkg::C_LAST_YY) begin
                    n_yy   = 7'd0;
                    n_cent = (r_cent == cds_pkg::C_LAST_CENT) ? 7'd0 : r_cent + 7'd1;
                end else begin
                    n_yy = r_yy + 7'd1;
                end
            end else if (r_day >= cds_pkg::f_month_len(r_month, cur_leap)) begin
                n_month = r_month + 4'd1;
                n_day   = 5'd1;
            end else begin
                n_day = r_day + 5'd1;
            end
        end else begin
            if (r_month == 4'd1 && r_day == 5'd1) begin
                n_month = cds_pkg::C_DEC_MONTH;
                n_day   = cds_pkg::C_LAST_DAY;
                if (r_yy == 7'd0) begin
                    n_yy   = cds_pkg::C_LAST_YY;
                    n_cent = (r_cent == 7'd0) ? cds_pkg::C_LAST_CENT : r_cent - 7'd1;
                end else begin
                    n_yy = r_yy - 7'd1;
                end
            end else if (r_day == 5'd1) begin
                n_month = prev_month;
                n_day   = cds_pkg::f_month_len(prev_month, cur_leap);
            end else begin
                n_day = r_day - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cent  <= cds_pkg::C_RESET_CENT;
            r_yy    <= cds_pkg::C_RESET_YY;
            r_month <= 4'd1;
            r_day   <= 5'd1;
        end else if (i_cmd.day_step) begin
            r_cent  <= n_cent;
            r_yy    <= n_yy;
            r_month <= n_month;
            r_day   <= n_day;
        end else if (i_cmd.load_check && load_ok) begin
            r_cent  <= r_quo;
            r_yy    <= r_rem[6:0];
            r_month <= r_lm;
            r_day   <= r_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_in.op;
            r_cnt    <= i_in.day_count;
            r_lm     <= i_in.load_month;
            r_ld     <= i_in.load_day;
            r_rem    <= (i_in.load_year >= cds_pkg::C_YEAR_SPAN)
                      ? i_in.load_year - cds_pkg::C_YEAR_SPAN : i_in.load_year;
            r_div_hi <= 1'b1;
            r_rej    <= 1'b0;
        end else begin
            if (i_cmd.day_step) begin
                r_cnt <= r_cnt - 16'd1;
            end
            if (i_cmd.div_step) begin
                if (r_div_hi) begin
                    r_quo <= quo_prod[25:19];
                end else begin
                    r_rem <= r_rem - cent_part;
                end
                r_div_hi <= 1'b0;
            end
            if (i_cmd.load_check) begin
                r_rej <= !load_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_out.cur_year      <= out_year;
            r_out.cur_month     <= r_month;
            r_out.cur_day       <= r_day;
            r_out.load_rejected <= r_rej;
        end
    end

endmodule

// ----- hw/rtl/calendar_date_stepper_core.sv -----
// Top level of the calendar date stepper: joins the controller and the datapath.
// Depends on cds_pkg, cds_ctrl and cds_dp.
//
//   Channel  Direction  Handshake           Payload
//   request  in         i_valid / o_stall   i_in  (cds_pkg::t_in)
//   result   out        o_valid / i_stall   o_out (cds_pkg::t_out)
//
// A step request moves the date by one day per cycle, day_count times, and then
// goes to done before the next request can be taken. A load splits the year
// into century and year, checks the date and goes to done. An unused operation
// goes straight to done. Reset is synchronous and sets 2000-01-01.
// The result register holds while i_stall is high; a new request is taken while
// it waits, and the next result is held back until it has been taken.
`timescale 1ns / 1ps

module calendar_date_stepper_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cds_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output cds_pkg::t_out o_out
);

    cds_pkg::t_cmd    cmd;
    cds_pkg::t_status status;

    cds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_in.op),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    cds_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .i_stall  (i_stall),
        .o_status (status),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule
